// ===== rtl/sbt_pkg.sv =====
// ----------------------------------------------------------------------------
// sbt_pkg
// Shared types and constants for the sorted bucket table: request kinds,
// response status codes, cell shift operations and the per-cell control word.
// ----------------------------------------------------------------------------
package sbt_pkg;

   // default geometry
   localparam int DEPTH_DEFAULT      = 16;
   localparam int KEY_BITS_DEFAULT   = 32;
   localparam int VALUE_BITS_DEFAULT = 32;

   // field widths fixed by the interface
   localparam int MODE_BITS      = 2;
   localparam int STATUS_BITS    = 2;
   localparam int COUNT_OUT_BITS = 5;
   localparam int THRESH_BITS    = 5;

   localparam logic [THRESH_BITS-1:0] THRESH_RESET = 5'd8;

   // request kinds
   typedef enum logic [MODE_BITS-1:0] {
      MODE_INSERT = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_FIND   = 2'd2,
      MODE_NOP    = 2'd3
   } mode_type;

   // response status codes
   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_DONE   = 2'd0,
      STATUS_ABSENT = 2'd1,
      STATUS_FULL   = 2'd2
   } status_type;

   // what a cell loads on the update cycle
   typedef enum logic [1:0] {
      CELL_HOLD  = 2'd0,
      CELL_NEW   = 2'd1,
      CELL_LEFT  = 2'd2,
      CELL_RIGHT = 2'd3
   } cell_op_type;

   // control word sent from the sequencer to every cell
   typedef struct packed {
      logic        capture;  // latch compare flags against the incoming request
      cell_op_type op;       // contents update
   } cell_ctl_type;

   // sequencer states, one-hot
   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_UPDATE = 2'b10
   } state_type;

endpackage

// ===== rtl/sorted_bucket_table.sv =====
// ----------------------------------------------------------------------------
// sorted_bucket_table
// Bounded key/value table kept sorted by (key, value) in a chain of cells.
// Supports insert at lower bound, remove of first key match and find.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid/req_ready    mode, key, value
//   rsp_      out        rsp_valid/rsp_ready    status, found_value,
//                                               entry_count, over_threshold
//   csr_      in         csr_wr_en              burst_threshold
//
// Each request runs as follows: the accept edge latches every cell's compare
// flags, then the update edge shifts the chain and loads the response register.
// The update waits while the response register holds a response not yet taken by rsp_ready.
// A new request is taken while a finished response still waits downstream.
// Synchronous reset empties the table and sets the threshold to 8.
// ----------------------------------------------------------------------------
module sorted_bucket_table #(
   parameter int DEPTH      = sbt_pkg::DEPTH_DEFAULT,
   parameter int KEY_BITS   = sbt_pkg::KEY_BITS_DEFAULT,
   parameter int VALUE_BITS = sbt_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [sbt_pkg::MODE_BITS-1:0]      req_mode,
   input  logic [KEY_BITS-1:0]                req_key,
   input  logic [VALUE_BITS-1:0]              req_value,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [sbt_pkg::STATUS_BITS-1:0]    rsp_status,
   output logic [VALUE_BITS-1:0]              rsp_found_value,
   output logic [sbt_pkg::COUNT_OUT_BITS-1:0] rsp_entry_count,
   output logic                               rsp_over_threshold,
   // configuration
   input  logic                               csr_wr_en,
   input  logic [sbt_pkg::THRESH_BITS-1:0]    csr_wr_data
);
   import sbt_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > THRESH_BITS) ? CNT_W : THRESH_BITS;

   // control state
   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [THRESH_BITS-1:0]    thresh_ff;
   logic                      rsp_valid_ff, rsp_valid_in;

   // latched request
   mode_type                  mode_ff;
   logic [KEY_BITS-1:0]       key_ff;
   logic [VALUE_BITS-1:0]     value_ff;

   // response payload
   logic [STATUS_BITS-1:0]    status_ff, status_in;
   logic [VALUE_BITS-1:0]     found_ff, found_in;
   logic [COUNT_OUT_BITS-1:0] entry_count_ff, entry_count_in;
   logic                      over_ff, over_in;

   // chain signals
   logic [KEY_BITS-1:0]       cell_key   [DEPTH];
   logic [VALUE_BITS-1:0]     cell_value [DEPTH];
   logic [DEPTH-1:0]          cell_ge;
   logic [DEPTH-1:0]          cell_eq;
   logic [DEPTH-1:0]          occupied;
   logic [DEPTH-1:0]          at_or_after;
   logic [DEPTH-1:0]          first;
   cell_op_type               ins_op [DEPTH];
   cell_op_type               rem_op [DEPTH];
   cell_ctl_type              ctl    [DEPTH];

   logic                      accept;
   logic                      fire;
   logic                      full;
   logic                      match;
   logic [VALUE_BITS-1:0]     match_value;
   logic                      do_insert;
   logic                      do_remove;
   logic [VALUE_BITS-1:0]     cmp_value;
   logic [CMP_W-1:0]          count_ext;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign fire      = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_ready);
   assign full      = (count_ff == CNT_W'(DEPTH));

   // insert compares on (key, value), remove and find on (key, 0)
   assign cmp_value = (mode_type'(req_mode) == MODE_INSERT) ? req_value : '0;

   // per-cell position flags
   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         // slots from the lower bound onward, free slots included
         assign occupied[gi]    = (CNT_W'(gi) < count_ff);
         assign at_or_after[gi] = cell_ge[gi] || !occupied[gi];

         if (gi == 0) begin : g_head
            assign first[gi]  = at_or_after[gi];
            assign ins_op[gi] = at_or_after[gi] ? CELL_NEW : CELL_HOLD;
         end else begin : g_body
            assign first[gi]  = at_or_after[gi] && !at_or_after[gi-1];
            assign ins_op[gi] = !at_or_after[gi]    ? CELL_HOLD :
                                at_or_after[gi-1]   ? CELL_LEFT : CELL_NEW;
         end
         assign rem_op[gi] = at_or_after[gi] ? CELL_RIGHT : CELL_HOLD;

         assign ctl[gi].capture = accept;
         assign ctl[gi].op      = do_insert ? ins_op[gi] :
                                  do_remove ? rem_op[gi] : CELL_HOLD;

         sbt_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS)
         ) u_cell (
            .clock       (clock),
            .ctl         (ctl[gi]),
            .cmp_key     (req_key),
            .cmp_value   (cmp_value),
            .new_key     (key_ff),
            .new_value   (value_ff),
            .left_key    (cell_key[(gi == 0) ? 0 : gi-1]),
            .left_value  (cell_value[(gi == 0) ? 0 : gi-1]),
            .right_key   (cell_key[(gi == DEPTH-1) ? gi : gi+1]),
            .right_value (cell_value[(gi == DEPTH-1) ? gi : gi+1]),
            .key         (cell_key[gi]),
            .value       (cell_value[gi]),
            .not_less    (cell_ge[gi]),
            .key_equal   (cell_eq[gi])
         );
      end
   endgenerate

   // key match at the lower bound, and its value
   always_comb begin
      match       = 1'b0;
      match_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (first[i] && occupied[i] && cell_eq[i]) begin
            match       = 1'b1;
            match_value = cell_value[i];
         end
      end
   end

   // request decode and response
   always_comb begin
      do_insert = 1'b0;
      do_remove = 1'b0;
      status_in = STATUS_DONE;
      found_in  = '0;
      count_in  = count_ff;
      case (mode_ff)
         MODE_INSERT: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               do_insert = fire;
               count_in  = count_ff + CNT_W'(1);
            end
         end
         MODE_REMOVE: begin
            if (match) begin
               do_remove = fire;
               count_in  = count_ff - CNT_W'(1);
            end else begin
               status_in = STATUS_ABSENT;
            end
         end
         MODE_FIND: begin
            if (match) begin
               found_in = match_value;
            end else begin
               status_in = STATUS_ABSENT;
            end
         end
         default: begin
            status_in = STATUS_DONE;
         end
      endcase
      count_ext      = CMP_W'(count_in);
      entry_count_in = count_ext[COUNT_OUT_BITS-1:0];
      over_in        = (count_ext > CMP_W'(thresh_ff));
   end

   // sequencer and response valid
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (fire) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         thresh_ff    <= THRESH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            count_ff <= count_in;
         end
         if (csr_wr_en) begin
            thresh_ff <= csr_wr_data;
         end
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= mode_type'(req_mode);
         key_ff   <= req_key;
         value_ff <= req_value;
      end
      if (fire) begin
         status_ff      <= status_in;
         found_ff       <= found_in;
         entry_count_ff <= entry_count_in;
         over_ff        <= over_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_found_value    = found_ff;
   assign rsp_entry_count    = entry_count_ff;
   assign rsp_over_threshold = over_ff;

endmodule

// ===== rtl/sbt_cell.sv =====
// ----------------------------------------------------------------------------
// sbt_cell
// One slot of the sorted chain: holds a key/value pair, compares it with the
// incoming request and shifts in from either neighbor or takes the new pair.
// ----------------------------------------------------------------------------
module sbt_cell #(
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  sbt_pkg::cell_ctl_type ctl,
   input  logic [KEY_BITS-1:0]   cmp_key,
   input  logic [VALUE_BITS-1:0] cmp_value,
   input  logic [KEY_BITS-1:0]   new_key,
   input  logic [VALUE_BITS-1:0] new_value,
   input  logic [KEY_BITS-1:0]   left_key,
   input  logic [VALUE_BITS-1:0] left_value,
   input  logic [KEY_BITS-1:0]   right_key,
   input  logic [VALUE_BITS-1:0] right_value,
   output logic [KEY_BITS-1:0]   key,
   output logic [VALUE_BITS-1:0] value,
   output logic                  not_less,
   output logic                  key_equal
);
   import sbt_pkg::*;

   logic [KEY_BITS-1:0]   key_ff,   key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  ge_ff,    ge_in;
   logic                  eq_ff,    eq_in;

   // stored pair against request: not less means (key, value) >= (cmp_key, cmp_value)
   always_comb begin
      eq_in = (key_ff == cmp_key);
      ge_in = (key_ff > cmp_key) || (eq_in && (value_ff >= cmp_value));
   end

   // contents select
   always_comb begin
      case (ctl.op)
         CELL_NEW: begin
            key_in   = new_key;
            value_in = new_value;
         end
         CELL_LEFT: begin
            key_in   = left_key;
            value_in = left_value;
         end
         CELL_RIGHT: begin
            key_in   = right_key;
            value_in = right_value;
         end
         default: begin
            key_in   = key_ff;
            value_in = value_ff;
         end
      endcase
   end

   // payload and flag registers
   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      if (ctl.capture) begin
         ge_ff <= ge_in;
         eq_ff <= eq_in;
      end
   end

   assign key       = key_ff;
   assign value     = value_ff;
   assign not_less  = ge_ff;
   assign key_equal = eq_ff;

endmodule
